>>> src/tfa_pkg.sv
// Shared types, constants and helpers for the sweep frame advance pipeline.
// Used by every module of the block but tfa_delay; depends on nothing.
package tfa_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 30;
    localparam int SQRT_STEPS    = 32;
    localparam int SOP_LAT       = 2;
    // Square and sum ahead of the root, the divider's integer step and its output stage after it.
    localparam int NORM_FIXED    = 2 + SQRT_STEPS + 2;

    typedef logic signed [DATA_W-1:0] q_t;
    typedef q_t [2:0] vec_t;

    // One frame as it travels down the pipeline.
    typedef struct packed {
        logic vld;
        logic rigid;
        logic kept;
        vec_t side;
        vec_t up;
        vec_t dir;
        vec_t tang;
    } frame_t;

    // A frame plus the normalized side axis once it exists.
    typedef struct packed {
        frame_t f;
        vec_t   x;
    } xframe_t;

    // Saturate a wide signed value to the 32-bit range.
    function automatic q_t sat32(input logic signed [65:0] v);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = 66'sd2147483647;
        lo = -66'sd2147483648;
        if (v > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (v < lo) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

>>> src/tfa_delay.sv
// Enable-gated delay line that keeps pipeline side data aligned with the math units.
// Depends on nothing beyond its parameters.
module tfa_delay #(
    parameter int W     = 1,
    parameter int DEPTH = 1
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] sr_reg [DEPTH];

    // Shift one place per advancing cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                sr_reg[i] <= '0;
            end
        end else if (en) begin
            sr_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++) begin
                sr_reg[i] <= sr_reg[i-1];
            end
        end
    end

    assign dout = sr_reg[DEPTH-1];

endmodule

>>> src/tfa_sop.sv
// Two-stage sum of three signed products, rounded half up and saturated to 32 bits.
// Depends on tfa_pkg.
module tfa_sop #(
    parameter int FRAC_BITS = tfa_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         en,
    input  tfa_pkg::vec_t a,
    input  tfa_pkg::vec_t b,
    input  logic [2:0]   neg,
    output tfa_pkg::q_t  y
);
    import tfa_pkg::*;

    localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

    logic signed [63:0] prod_next [3];
    logic signed [63:0] prod_reg  [3];
    logic signed [65:0] sum;
    logic signed [65:0] rnd;
    q_t                 y_reg;

    // Products, negated where the term subtracts.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod_next[i] = a[i] * b[i];
            if (neg[i]) begin
                prod_next[i] = -prod_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                prod_reg[i] <= prod_next[i];
            end
        end
    end

    // Exact sum, then round to the fraction width and saturate.
    assign sum = 66'(prod_reg[0]) + 66'(prod_reg[1]) + 66'(prod_reg[2]);
    assign rnd = (sum + HALF) >>> FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= sat32(rnd);
        end
    end

    assign y = y_reg;

endmodule

>>> src/tfa_isqrt.sv
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// Depends on tfa_pkg.
module tfa_isqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] s,
    output logic [31:0] r
);
    import tfa_pkg::*;

    logic [63:0] s_reg  [SQRT_STEPS];
    logic [63:0] r_reg  [SQRT_STEPS];
    logic [63:0] s_next [SQRT_STEPS];
    logic [63:0] r_next [SQRT_STEPS];
    logic [63:0] s_in   [SQRT_STEPS];
    logic [63:0] r_in   [SQRT_STEPS];
    logic [63:0] trial  [SQRT_STEPS];

    // Each stage tests one bit of the root against the remaining radicand.
    always_comb begin
        for (int k = 0; k < SQRT_STEPS; k++) begin
            if (k == 0) begin
                s_in[k] = s;
                r_in[k] = '0;
            end else begin
                s_in[k] = s_reg[k-1];
                r_in[k] = r_reg[k-1];
            end
            trial[k] = r_in[k] + (64'd1 << (62 - 2 * k));
            if (s_in[k] >= trial[k]) begin
                s_next[k] = s_in[k] - trial[k];
                r_next[k] = (r_in[k] >> 1) + (64'd1 << (62 - 2 * k));
            end else begin
                s_next[k] = s_in[k];
                r_next[k] = r_in[k] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                s_reg[k] <= s_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign r = r_reg[SQRT_STEPS-1][31:0];

endmodule

>>> src/tfa_div.sv
// Pipelined restoring divider: |v| * 2^FRAC_BITS / len, rounded, signed and saturated.
// Depends on tfa_pkg.
module tfa_div #(
    parameter int FRAC_BITS = tfa_pkg::FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] mag,
    input  logic        neg,
    input  logic [31:0] len,
    output tfa_pkg::q_t y
);
    import tfa_pkg::*;

    localparam int QW = FRAC_BITS + 1;

    logic [31:0]   rem_reg  [FRAC_BITS+1];
    logic [31:0]   rem_next [FRAC_BITS+1];
    logic [QW-1:0] q_reg    [FRAC_BITS+1];
    logic [QW-1:0] q_next   [FRAC_BITS+1];
    logic [31:0]   len_reg  [FRAC_BITS+1];
    logic [31:0]   len_next [FRAC_BITS+1];
    logic          neg_reg  [FRAC_BITS+1];
    logic          neg_next [FRAC_BITS+1];
    logic          zero_reg [FRAC_BITS+1];
    logic          zero_next[FRAC_BITS+1];
    logic [32:0]   r2       [FRAC_BITS+1];
    logic [32:0]   rr;
    logic [QW:0]   qr;
    logic [63:0]   qq;
    logic signed [65:0] val;
    q_t            y_reg;
    q_t            y_next;

    // Integer part first, then one fraction bit per stage.
    always_comb begin
        r2[0]        = '0;
        len_next[0]  = len;
        neg_next[0]  = neg;
        zero_next[0] = (len == '0);
        if (mag >= len) begin
            q_next[0]   = QW'(1);
            rem_next[0] = mag - len;
        end else begin
            q_next[0]   = '0;
            rem_next[0] = mag;
        end
        for (int j = 1; j <= FRAC_BITS; j++) begin
            r2[j]        = {rem_reg[j-1], 1'b0};
            len_next[j]  = len_reg[j-1];
            neg_next[j]  = neg_reg[j-1];
            zero_next[j] = zero_reg[j-1];
            q_next[j]    = {q_reg[j-1][QW-2:0], 1'b0};
            if (r2[j] >= {1'b0, len_reg[j-1]}) begin
                rem_next[j]  = 32'(r2[j] - {1'b0, len_reg[j-1]});
                q_next[j][0] = 1'b1;
            end else begin
                rem_next[j] = r2[j][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j <= FRAC_BITS; j++) begin
                rem_reg[j]  <= rem_next[j];
                q_reg[j]    <= q_next[j];
                len_reg[j]  <= len_next[j];
                neg_reg[j]  <= neg_next[j];
                zero_reg[j] <= zero_next[j];
            end
        end
    end

    // Round to nearest on the next bit, cap the magnitude, apply the sign; a zero length gives zero.
    always_comb begin
        rr = {rem_reg[FRAC_BITS], 1'b0};
        qr = {1'b0, q_reg[FRAC_BITS]};
        if (rr >= {1'b0, len_reg[FRAC_BITS]}) begin
            qr = qr + (QW+1)'(1);
        end
        qq = 64'(qr);
        if (qq > 64'h8000_0000) begin
            qq = 64'h8000_0000;
        end
        val = $signed({2'b00, qq});
        if (neg_reg[FRAC_BITS]) begin
            val = -val;
        end
        if (zero_reg[FRAC_BITS]) begin
            y_next = '0;
        end else begin
            y_next = sat32(val);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

endmodule

>>> src/tfa_norm.sv
// Vector normalizer: sum of squares, pipelined root, three pipelined dividers.
// Depends on tfa_pkg, tfa_isqrt, tfa_div and tfa_delay.
module tfa_norm #(
    parameter int FRAC_BITS = tfa_pkg::FRAC_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  tfa_pkg::vec_t v,
    output tfa_pkg::vec_t n
);
    import tfa_pkg::*;

    logic [63:0] sq_reg [3];
    logic signed [63:0] sq_next [3];
    vec_t        v1_reg;
    vec_t        v2_reg;
    logic [63:0] s_reg;
    logic [31:0] len;
    vec_t        v_late;
    logic [31:0] mag [3];

    // Squares of the raw components.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sq_next[i] = v[i] * v[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= sq_next[i];
            end
            v1_reg <= v;
            s_reg  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            v2_reg <= v1_reg;
        end
    end

    tfa_isqrt u_isqrt (
        .aclk (aclk),
        .en   (en),
        .s    (s_reg),
        .r    (len)
    );

    // Hold the components until the length comes out of the root.
    tfa_delay #(
        .W     ($bits(vec_t)),
        .DEPTH (SQRT_STEPS)
    ) u_vdly (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .din     (v2_reg),
        .dout    (v_late)
    );

    // One divider per component.
    for (genvar i = 0; i < 3; i++) begin : g_div
        assign mag[i] = v_late[i][31] ? 32'(-v_late[i]) : 32'(v_late[i]);
        tfa_div #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .aclk (aclk),
            .en   (en),
            .mag  (mag[i]),
            .neg  (v_late[i][31]),
            .len  (len),
            .y    (n[i])
        );
    end

endmodule

>>> src/tube_frame_advance.sv
// Top level of the sweep frame advance block: beat interfaces, config register, pipeline.
// Depends on tfa_pkg, tfa_delay, tfa_sop and tfa_norm.
//
// Takes one frame-plus-tangent beat per clock while s_tready is high and returns
// one next-frame beat per beat taken, in order, in Q1.30 at the default FRAC_BITS.
// Two normalize stages run in series, each a 32-stage square-root pipeline
// followed by a FRAC_BITS+2 stage divider pipeline. The whole pipeline advances
// whenever the output register is empty or being taken, so s_tready drops only
// while m_tvalid is high and m_tready is low. rigid_mode is sampled with each beat.
module tube_frame_advance #(
    parameter int FRAC_BITS = tfa_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration write channel: rigid_mode.
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data,
    // Input beats.
    input  logic         s_tvalid,
    output logic         s_tready,
    // old_side_x/y/z, old_up_x/y/z, old_dir_x/y/z, tan_x/y/z, 32 bits each, lowest first
    input  logic [383:0] s_tdata,
    // Result beats.
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_side_x/y/z, new_up_x/y/z, new_dir_x/y/z, 32 bits each, lowest first
    output logic [287:0] m_tdata,
    // frame_kept
    output logic [0:0]   m_tuser
);
    import tfa_pkg::*;

    localparam int NORM_LAT = NORM_FIXED + FRAC_BITS;
    localparam logic signed [63:0] ONE_Q = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] KEEP_LIMIT = ONE_Q - ((ONE_Q + 64'sd50000) / 64'sd100000);
    localparam q_t ONE_SAT = (ONE_Q > 64'sd2147483647) ? 32'sh7FFF_FFFF : ONE_Q[31:0];

    logic    rigid_reg;
    logic    en;
    frame_t  f0;
    frame_t  fa_raw;
    frame_t  fa;
    frame_t  fb;
    xframe_t xb;
    xframe_t xc;
    xframe_t xd;
    xframe_t xe;
    vec_t    cross_a;
    vec_t    xa;
    vec_t    xn;
    vec_t    yc;
    vec_t    yn;
    vec_t    csn;
    vec_t    row0;
    vec_t    row1;
    vec_t    ca_a [3];
    vec_t    ca_b [3];
    vec_t    cy_a [3];
    vec_t    cy_b [3];
    vec_t    r0_a [3];
    vec_t    r0_b [3];
    vec_t    r1_a [3];
    vec_t    r1_b [3];
    vec_t    cs_vec;
    vec_t    zero_vec;
    q_t      dot_td;
    q_t      cs0;
    q_t      cs1;
    q_t      cos_q;
    q_t      sin_q;
    logic    m_valid_reg;
    logic    m_kept_reg;
    vec_t    m_side_reg;
    vec_t    m_up_reg;
    vec_t    m_dir_reg;
    vec_t    out_side;
    vec_t    out_up;
    vec_t    out_dir;

    // Configuration register, writable at any time.
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rigid_reg <= 1'b0;
        end else if (cfg_valid) begin
            rigid_reg <= cfg_data;
        end
    end

    // The pipeline moves whenever the output register can take a beat.
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign zero_vec = '0;

    // Unpack the input beat.
    always_comb begin
        f0.vld   = s_tvalid;
        f0.rigid = rigid_reg;
        f0.kept  = 1'b0;
        for (int i = 0; i < 3; i++) begin
            f0.side[i] = s_tdata[32*i +: 32];
            f0.up[i]   = s_tdata[96 + 32*i +: 32];
            f0.dir[i]  = s_tdata[192 + 32*i +: 32];
            f0.tang[i] = s_tdata[288 + 32*i +: 32];
        end
        cross_a = rigid_reg ? f0.up : f0.dir;
    end

    // Stage A: alignment dot product and the raw side axis cross product.
    tfa_sop #(.FRAC_BITS(FRAC_BITS)) u_dot_td (
        .aclk (aclk), .en (en), .a (f0.tang), .b (f0.dir), .neg (3'b000), .y (dot_td)
    );

    for (genvar i = 0; i < 3; i++) begin : g_cross_x
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        always_comb begin
            ca_a[i]    = '0;
            ca_b[i]    = '0;
            ca_a[i][0] = cross_a[J];
            ca_a[i][1] = cross_a[K];
            ca_b[i][0] = f0.tang[K];
            ca_b[i][1] = f0.tang[J];
        end
        tfa_sop #(.FRAC_BITS(FRAC_BITS)) u_sop (
            .aclk (aclk), .en (en), .a (ca_a[i]), .b (ca_b[i]), .neg (3'b010), .y (xa[i])
        );
    end

    tfa_delay #(.W($bits(frame_t)), .DEPTH(SOP_LAT)) u_dly_a (
        .aclk (aclk), .aresetn (aresetn), .en (en), .din (f0), .dout (fa_raw)
    );

    // Frame is kept when the tangent is nearly the old direction.
    always_comb begin
        fa      = fa_raw;
        fa.kept = (64'(dot_td) > KEEP_LIMIT);
    end

    // Stage B: normalize the side axis.
    tfa_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_x (
        .aclk (aclk), .aresetn (aresetn), .en (en), .v (xa), .n (xn)
    );

    tfa_delay #(.W($bits(frame_t)), .DEPTH(NORM_LAT)) u_dly_b (
        .aclk (aclk), .aresetn (aresetn), .en (en), .din (fa), .dout (fb)
    );

    assign xb.f = fb;
    assign xb.x = xn;

    // Stage C: twist dot products and the up axis cross product.
    tfa_sop #(.FRAC_BITS(FRAC_BITS)) u_dot_xs (
        .aclk (aclk), .en (en), .a (xn), .b (fb.side), .neg (3'b000), .y (cs0)
    );
    tfa_sop #(.FRAC_BITS(FRAC_BITS)) u_dot_xu (
        .aclk (aclk), .en (en), .a (xn), .b (fb.up), .neg (3'b000), .y (cs1)
    );

    for (genvar i = 0; i < 3; i++) begin : g_cross_y
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        always_comb begin
            cy_a[i]    = '0;
            cy_b[i]    = '0;
            cy_a[i][0] = fb.tang[J];
            cy_a[i][1] = fb.tang[K];
            cy_b[i][0] = xn[K];
            cy_b[i][1] = xn[J];
        end
        tfa_sop #(.FRAC_BITS(FRAC_BITS)) u_sop (
            .aclk (aclk), .en (en), .a (cy_a[i]), .b (cy_b[i]), .neg (3'b010), .y (yc[i])
        );
    end

    tfa_delay #(.W($bits(xframe_t)), .DEPTH(SOP_LAT)) u_dly_c (
        .aclk (aclk), .aresetn (aresetn), .en (en), .din (xb), .dout (xc)
    );

    // Stage D: normalize the twist pair and the up axis side by side.
    always_comb begin
        cs_vec    = zero_vec;
        cs_vec[0] = cs0;
        cs_vec[1] = cs1;
    end

    tfa_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_cs (
        .aclk (aclk), .aresetn (aresetn), .en (en), .v (cs_vec), .n (csn)
    );
    tfa_norm #(.FRAC_BITS(FRAC_BITS)) u_norm_y (
        .aclk (aclk), .aresetn (aresetn), .en (en), .v (yc), .n (yn)
    );

    tfa_delay #(.W($bits(xframe_t)), .DEPTH(NORM_LAT)) u_dly_d (
        .aclk (aclk), .aresetn (aresetn), .en (en), .din (xc), .dout (xd)
    );

    // No twist when both dot products vanish: cosine one, sine zero.
    assign cos_q = (csn[0] == '0 && csn[1] == '0) ? ONE_SAT : csn[0];
    assign sin_q = csn[1];

    // Stage E: rotate the axes by the twist angle.
    for (genvar i = 0; i < 3; i++) begin : g_rot
        always_comb begin
            r0_a[i]    = '0;
            r0_b[i]    = '0;
            r1_a[i]    = '0;
            r1_b[i]    = '0;
            r0_a[i][0] = cos_q;
            r0_a[i][1] = sin_q;
            r0_b[i][0] = xd.x[i];
            r0_b[i][1] = yn[i];
            r1_a[i][0] = sin_q;
            r1_a[i][1] = cos_q;
            r1_b[i][0] = xd.x[i];
            r1_b[i][1] = yn[i];
        end
        tfa_sop #(.FRAC_BITS(FRAC_BITS)) u_row0 (
            .aclk (aclk), .en (en), .a (r0_a[i]), .b (r0_b[i]), .neg (3'b010), .y (row0[i])
        );
        tfa_sop #(.FRAC_BITS(FRAC_BITS)) u_row1 (
            .aclk (aclk), .en (en), .a (r1_a[i]), .b (r1_b[i]), .neg (3'b000), .y (row1[i])
        );
    end

    tfa_delay #(.W($bits(xframe_t)), .DEPTH(SOP_LAT)) u_dly_e (
        .aclk (aclk), .aresetn (aresetn), .en (en), .din (xd), .dout (xe)
    );

    // Pick the result: the old frame when kept, else by mode.
    always_comb begin
        if (xe.f.kept) begin
            out_side = xe.f.side;
            out_up   = xe.f.up;
            out_dir  = xe.f.dir;
        end else if (xe.f.rigid) begin
            out_side = xe.x;
            out_up   = xe.f.up;
            out_dir  = xe.f.tang;
        end else begin
            out_side = row0;
            out_up   = row1;
            out_dir  = xe.f.tang;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= xe.f.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_kept_reg <= xe.f.kept;
            m_side_reg <= out_side;
            m_up_reg   <= out_up;
            m_dir_reg  <= out_dir;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tuser[0] = m_kept_reg;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m_tdata[32*i +: 32]       = m_side_reg[i];
            m_tdata[96 + 32*i +: 32]  = m_up_reg[i];
            m_tdata[192 + 32*i +: 32] = m_dir_reg[i];
        end
    end

`ifndef ASSERT_OFF
    // A held result must stall the input side.
    a_stall_blocks_input: assert property (@(posedge aclk)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while the output is stalled");

    // A kept frame carries the old direction, which cannot be zero.
    a_kept_dir_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[287:192] != '0))
        else $error("kept frame with a zero direction row");

    // Nothing comes out right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule
